// File: sv/slt_pkg.sv
// shared types and codes for the sorted linked-list key table
package slt_pkg;

    typedef logic        [2:0]  t_cmd_code;
    typedef logic signed [31:0] t_key;
    typedef logic        [5:0]  t_slot;
    typedef logic        [2:0]  t_status;
    typedef logic        [5:0]  t_position;
    typedef logic        [6:0]  t_count;

    localparam t_cmd_code CMD_INSERT   = 3'd0;
    localparam t_cmd_code CMD_DELETE   = 3'd1;
    localparam t_cmd_code CMD_SEARCH   = 3'd2;
    localparam t_cmd_code CMD_COUNT    = 3'd3;
    localparam t_cmd_code CMD_LAST_KEY = 3'd4;
    localparam t_cmd_code CMD_SLOT_KEY = 3'd5;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_MISSING = 3'd1;
    localparam t_status ST_FULL    = 3'd2;
    localparam t_status ST_DUP     = 3'd3;
    localparam t_status ST_EMPTY   = 3'd4;

endpackage

// File: sv/slt_cmd_if.sv
// command channel: valid/ready handshake with one command item
interface slt_cmd_if;
    import slt_pkg::*;

    logic      valid;
    logic      ready;
    t_cmd_code command;
    t_key      key;
    t_slot     slot;

    modport source (output valid, output command, output key, output slot, input ready);
    modport sink   (input valid, input command, input key, input slot, output ready);
endinterface

// File: sv/slt_res_if.sv
// result channel: valid/ready handshake with one result item
interface slt_res_if;
    import slt_pkg::*;

    logic      valid;
    logic      ready;
    t_status   status;
    t_position position;
    t_key      value;
    t_count    count;

    modport source (output valid, output status, output position, output value,
                    output count, input ready);
    modport sink   (input valid, input status, input position, input value,
                    input count, output ready);
endinterface

// File: sv/sorted_linked_list_table_unit.sv
// sorted linked-list key table with free list, kept in slot memories
//
//   channel   direction  handshake           payload
//   i_cmd     in         valid/ready         command, key, slot
//   o_res     out        valid/ready         status, position, value, count
//
// walks: search, delete and insert visit list entries with a memory read, then
//   a compare, per entry; last key walks the whole list the same way
// reset: after i_rst_n a clearing pass rebuilds the key and link memories;
//   no item is accepted until it ends
// stalls: one item at a time; a finished result waits in the output register
//   while the next item is accepted, and a result only stalls if the previous
//   one has still not been taken
module sorted_linked_list_table_unit #(
    parameter int ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slt_cmd_if.sink       i_cmd,
    slt_res_if.source     o_res
);
    import slt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = $clog2(ENTRIES + 1);
    localparam logic [LW-1:0] NIL     = LW'(ENTRIES);
    localparam logic [IW-1:0] LAST_IX = IW'(ENTRIES - 1);

    typedef enum logic [13:0] {
        S_CLEAR   = 14'b00000000000001,
        S_IDLE    = 14'b00000000000010,
        S_WALK_RD = 14'b00000000000100,
        S_WALK_EV = 14'b00000000001000,
        S_LAST_RD = 14'b00000000010000,
        S_LAST_EV = 14'b00000000100000,
        S_SLOT_RD = 14'b00000001000000,
        S_SLOT_EV = 14'b00000010000000,
        S_INS_RD  = 14'b00000100000000,
        S_INS_WR1 = 14'b00001000000000,
        S_INS_WR2 = 14'b00010000000000,
        S_DEL_WR1 = 14'b00100000000000,
        S_DEL_WR2 = 14'b01000000000000,
        S_DONE    = 14'b10000000000000
    } t_state;

    // control state
    t_state        r_state, n_state;
    logic [IW-1:0] r_clr_idx, n_clr_idx;
    logic [LW-1:0] r_head, n_head;
    logic [LW-1:0] r_free, n_free;
    logic [LW-1:0] r_count, n_count;
    logic          r_out_valid;

    // per-item working registers
    t_cmd_code     r_cmd, n_cmd;
    t_key          r_key, n_key;
    t_slot         r_slot, n_slot;
    logic [LW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_prev, n_prev;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_nxt, n_nxt;
    logic [LW-1:0] r_steps, n_steps;
    t_status       r_res_status, n_res_status;
    t_position     r_res_position, n_res_position;
    t_key          r_res_value, n_res_value;
    t_count        r_res_count, n_res_count;

    // output register
    t_status       r_out_status;
    t_position     r_out_position;
    t_key          r_out_value;
    t_count        r_out_count;

    // slot memories
    t_key          key_mem [ENTRIES];
    logic [LW-1:0] link_mem [ENTRIES];
    t_key          r_key_rd;
    logic [LW-1:0] r_link_rd;

    logic          mem_key_we;
    logic          mem_link_we;
    logic [IW-1:0] mem_addr;
    t_key          mem_key_wd;
    logic [LW-1:0] mem_link_wd;

    logic          cmd_take;
    logic          out_load;
    logic          walk_end;
    logic          walk_found;

    assign cmd_take = i_cmd.valid && i_cmd.ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    assign i_cmd.ready    = (r_state == S_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.status   = r_out_status;
    assign o_res.position = r_out_position;
    assign o_res.value    = r_out_value;
    assign o_res.count    = r_out_count;

    // memory port: one address per cycle, shared by read and write
    always_comb begin
        mem_key_we  = 1'b0;
        mem_link_we = 1'b0;
        mem_addr    = r_cur[IW-1:0];
        mem_key_wd  = r_key;
        mem_link_wd = r_cur;
        unique case (r_state)
            S_CLEAR: begin
                mem_addr    = r_clr_idx;
                mem_key_we  = 1'b1;
                mem_link_we = 1'b1;
                mem_key_wd  = '0;
                mem_link_wd = LW'(r_clr_idx) + LW'(1);
            end
            S_SLOT_RD: begin
                mem_addr = IW'(r_slot);
            end
            S_INS_RD: begin
                mem_addr = r_free[IW-1:0];
            end
            S_INS_WR1: begin
                // new slot takes the key and links to the node it goes before
                mem_addr    = r_pos[IW-1:0];
                mem_key_we  = 1'b1;
                mem_link_we = 1'b1;
                mem_link_wd = r_cur;
            end
            S_INS_WR2: begin
                mem_addr    = r_prev[IW-1:0];
                mem_link_we = (r_prev < NIL);
                mem_link_wd = r_pos;
            end
            S_DEL_WR1: begin
                mem_addr    = r_prev[IW-1:0];
                mem_link_we = (r_prev < NIL);
                mem_link_wd = r_nxt;
            end
            S_DEL_WR2: begin
                mem_addr    = r_pos[IW-1:0];
                mem_link_we = 1'b1;
                mem_link_wd = r_free;
            end
            default: begin
                mem_addr = r_cur[IW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_key_we) begin
            key_mem[mem_addr] <= mem_key_wd;
        end
        if (mem_link_we) begin
            link_mem[mem_addr] <= mem_link_wd;
        end
        r_key_rd  <= key_mem[mem_addr];
        r_link_rd <= link_mem[mem_addr];
    end

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_clr_idx      = r_clr_idx;
        n_head         = r_head;
        n_free         = r_free;
        n_count        = r_count;
        n_cmd          = r_cmd;
        n_key          = r_key;
        n_slot         = r_slot;
        n_cur          = r_cur;
        n_prev         = r_prev;
        n_pos          = r_pos;
        n_nxt          = r_nxt;
        n_steps        = r_steps;
        n_res_status   = r_res_status;
        n_res_position = r_res_position;
        n_res_value    = r_res_value;
        n_res_count    = r_res_count;
        walk_end       = 1'b0;
        walk_found     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + IW'(1);
                if (r_clr_idx == LAST_IX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_take) begin
                    n_cmd          = i_cmd.command;
                    n_key          = i_cmd.key;
                    n_slot         = i_cmd.slot;
                    n_res_status   = ST_OK;
                    n_res_position = '0;
                    n_res_value    = '0;
                    n_res_count    = '0;
                    n_cur          = r_head;
                    n_prev         = NIL;
                    n_steps        = '0;
                    unique case (i_cmd.command) inside
                        CMD_INSERT: begin
                            if (r_free >= NIL) begin
                                n_res_status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_WALK_RD;
                            end
                        end
                        CMD_DELETE, CMD_SEARCH: begin
                            n_state = S_WALK_RD;
                        end
                        CMD_COUNT: begin
                            n_res_count = t_count'(r_count);
                            n_state     = S_DONE;
                        end
                        CMD_LAST_KEY: begin
                            if (r_head >= NIL) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_LAST_RD;
                            end
                        end
                        CMD_SLOT_KEY: begin
                            if (int'(i_cmd.slot) < ENTRIES) begin
                                n_state = S_SLOT_RD;
                            end else begin
                                n_res_status = ST_MISSING;
                                n_state      = S_DONE;
                            end
                        end
                        default: begin
                            n_res_status = ST_MISSING;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK_RD: begin
                if (r_cur >= NIL || r_steps == NIL) begin
                    walk_end = 1'b1;
                end else begin
                    n_state = S_WALK_EV;
                end
            end
            S_WALK_EV: begin
                if (r_key_rd == r_key) begin
                    walk_end   = 1'b1;
                    walk_found = 1'b1;
                    n_pos      = r_cur;
                    n_nxt      = r_link_rd;
                end else if (r_key_rd > r_key) begin
                    // passed a larger key: stop early
                    walk_end = 1'b1;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = r_link_rd;
                    n_steps = r_steps + LW'(1);
                    n_state = S_WALK_RD;
                end
            end
            S_LAST_RD: begin
                n_state = S_LAST_EV;
            end
            S_LAST_EV: begin
                if (r_link_rd >= NIL || r_steps == NIL) begin
                    n_res_value = r_key_rd;
                    n_state     = S_DONE;
                end else begin
                    n_cur   = r_link_rd;
                    n_steps = r_steps + LW'(1);
                    n_state = S_LAST_RD;
                end
            end
            S_SLOT_RD: begin
                n_state = S_SLOT_EV;
            end
            S_SLOT_EV: begin
                n_res_value = r_key_rd;
                n_state     = S_DONE;
            end
            S_INS_RD: begin
                n_pos   = r_free;
                n_state = S_INS_WR1;
            end
            S_INS_WR1: begin
                n_free  = r_link_rd;
                n_count = r_count + LW'(1);
                n_state = S_INS_WR2;
            end
            S_INS_WR2: begin
                if (r_prev >= NIL) begin
                    n_head = r_pos;
                end
                n_state = S_DONE;
            end
            S_DEL_WR1: begin
                if (r_prev >= NIL) begin
                    n_head = r_nxt;
                end
                n_state = S_DEL_WR2;
            end
            S_DEL_WR2: begin
                n_free = r_pos;
                if (r_count != '0) begin
                    n_count = r_count - LW'(1);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // what to do once a walk has found the key or its place
        if (walk_end) begin
            unique case (r_cmd) inside
                CMD_INSERT: begin
                    if (walk_found) begin
                        n_res_status = ST_DUP;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_INS_RD;
                    end
                end
                CMD_DELETE: begin
                    if (walk_found) begin
                        n_state = S_DEL_WR1;
                    end else begin
                        n_res_status = ST_MISSING;
                        n_state      = S_DONE;
                    end
                end
                default: begin
                    if (walk_found) begin
                        n_res_position = t_position'(r_cur);
                    end else begin
                        n_res_status = ST_MISSING;
                    end
                    n_state = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_head      <= NIL;
            r_free      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_head    <= n_head;
            r_free    <= n_free;
            r_count   <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_key          <= n_key;
        r_slot         <= n_slot;
        r_cur          <= n_cur;
        r_prev         <= n_prev;
        r_pos          <= n_pos;
        r_nxt          <= n_nxt;
        r_steps        <= n_steps;
        r_res_status   <= n_res_status;
        r_res_position <= n_res_position;
        r_res_value    <= n_res_value;
        r_res_count    <= n_res_count;
        if (out_load) begin
            r_out_status   <= r_res_status;
            r_out_position <= r_res_position;
            r_out_value    <= r_res_value;
            r_out_count    <= r_res_count;
        end
    end

    // no item is taken while the memories are still being rebuilt
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_cmd.ready)
        else $error("command accepted during clearing pass");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("entry count above capacity");

    // an empty free list means every slot holds a key
    a_free_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free >= NIL) |-> (r_count == NIL))
        else $error("free list and entry count disagree");

    // a result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> !$past(out_load))
        else $error("pending result overwritten");

endmodule

// File: test/testbench.sv
// testbench for the sorted linked-list key table: directed table, then phased random traffic
`timescale 1ns / 1ps

module testbench;
    import slt_pkg::*;

    localparam int ENTRIES = 64;
    localparam logic [6:0] NO_SLOT = 7'(ENTRIES);
    localparam t_cmd_code CMD_SPARE_LO = 3'd6;
    localparam t_cmd_code CMD_SPARE_HI = 3'd7;
    localparam t_key KEY_MAX = 32'sh7fff_ffff;
    localparam t_key KEY_MIN = 32'sh8000_0000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int SETTLE_CYCLES = 2 * ENTRIES + 20;

    typedef struct packed {
        t_status   status;
        t_position position;
        t_key      value;
        t_count    count;
    } t_outcome;

    typedef struct packed {
        t_cmd_code command;
        t_key      key;
        t_slot     slot;
        logic      typed;
        t_outcome  want;
    } t_step;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED} t_phase;

    localparam t_outcome NO_WANT = '0;
    localparam t_outcome OK_PLAIN = '{ST_OK, 6'd0, 32'sd0, 7'd0};
    localparam t_outcome MISS_PLAIN = '{ST_MISSING, 6'd0, 32'sd0, 7'd0};

    localparam t_step DIRECTED_STEPS [25] = '{
        '{CMD_COUNT,    32'sd0,  6'd0,  1'b1, OK_PLAIN},
        '{CMD_LAST_KEY, 32'sd0,  6'd0,  1'b1, '{ST_EMPTY, 6'd0, 32'sd0, 7'd0}},
        '{CMD_SEARCH,   32'sd5,  6'd0,  1'b1, MISS_PLAIN},
        '{CMD_DELETE,   32'sd5,  6'd0,  1'b1, MISS_PLAIN},
        '{CMD_SLOT_KEY, 32'sd0,  6'd0,  1'b1, OK_PLAIN},
        '{CMD_SLOT_KEY, 32'sd0,  6'd63, 1'b1, OK_PLAIN},
        '{CMD_INSERT,   KEY_MAX, 6'd0,  1'b1, OK_PLAIN},
        '{CMD_INSERT,   KEY_MIN, 6'd0,  1'b1, OK_PLAIN},
        '{CMD_INSERT,   32'sd0,  6'd0,  1'b1, OK_PLAIN},
        '{CMD_INSERT,   KEY_MIN, 6'd0,  1'b1, '{ST_DUP, 6'd0, 32'sd0, 7'd0}},
        '{CMD_INSERT,   -32'sd1, 6'd0,  1'b0, NO_WANT},
        '{CMD_SEARCH,   KEY_MIN, 6'd0,  1'b0, NO_WANT},
        '{CMD_SEARCH,   KEY_MAX, 6'd0,  1'b0, NO_WANT},
        '{CMD_SEARCH,   32'sd1,  6'd0,  1'b0, NO_WANT},
        '{CMD_LAST_KEY, 32'sd0,  6'd0,  1'b0, NO_WANT},
        '{CMD_COUNT,    32'sd0,  6'd0,  1'b1, '{ST_OK, 6'd0, 32'sd0, 7'd4}},
        '{CMD_SPARE_LO, 32'sd0,  6'd0,  1'b1, MISS_PLAIN},
        '{CMD_SPARE_HI, -32'sd1, 6'd63, 1'b1, MISS_PLAIN},
        '{CMD_DELETE,   KEY_MAX, 6'd0,  1'b0, NO_WANT},
        '{CMD_DELETE,   KEY_MIN, 6'd0,  1'b0, NO_WANT},
        '{CMD_SLOT_KEY, 32'sd0,  6'd1,  1'b0, NO_WANT},
        '{CMD_INSERT,   32'sd7,  6'd0,  1'b0, NO_WANT},
        '{CMD_LAST_KEY, 32'sd0,  6'd0,  1'b0, NO_WANT},
        '{CMD_DELETE,   32'sd0,  6'd0,  1'b0, NO_WANT},
        '{CMD_COUNT,    32'sd0,  6'd0,  1'b0, NO_WANT}
    };

    logic i_clk;
    logic i_rst_n;

    slt_cmd_if cmd_if ();
    slt_res_if res_if ();

    sorted_linked_list_table_unit #(
        .ENTRIES (ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // shadow copy of the table
    t_key       table_keys  [ENTRIES];
    logic [6:0] table_links [ENTRIES];
    logic [6:0] head_slot;
    logic [6:0] free_slot;
    t_count     key_total;

    t_outcome expected_results [$];
    int       fault_count = 0;
    bit       steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #16_000_000;
        $display("FAILURE");
        $finish;
    end

    // walk the sorted list; prior gets the slot before the match or insertion point
    function automatic logic [6:0] find_key(input t_key k, output logic [6:0] prior);
        logic [6:0] cur;
        int         steps;
        cur = head_slot;
        prior = NO_SLOT;
        steps = 0;
        while (cur < NO_SLOT && steps < ENTRIES) begin
            if (table_keys[cur] == k) return cur;
            if (table_keys[cur] > k) return NO_SLOT;
            prior = cur;
            cur = table_links[cur];
            steps++;
        end
        return NO_SLOT;
    endfunction

    function automatic t_outcome apply_cmd(input t_cmd_code c, input t_key k, input t_slot s);
        t_outcome   res;
        logic [6:0] at;
        logic [6:0] prior;
        int         steps;
        res = '0;
        res.status = ST_OK;
        case (c)
            CMD_INSERT: begin
                at = NO_SLOT;
                if (free_slot >= NO_SLOT) begin
                    res.status = ST_FULL;
                end else begin
                    at = find_key(k, prior);
                    if (at < NO_SLOT) begin
                        res.status = ST_DUP;
                    end else begin
                        at = free_slot;
                        free_slot = table_links[at];
                        table_keys[at] = k;
                        if (prior < NO_SLOT) begin
                            table_links[at] = table_links[prior];
                            table_links[prior] = at;
                        end else begin
                            table_links[at] = head_slot;
                            head_slot = at;
                        end
                        key_total++;
                    end
                end
            end
            CMD_DELETE: begin
                at = find_key(k, prior);
                if (at >= NO_SLOT) begin
                    res.status = ST_MISSING;
                end else begin
                    if (prior < NO_SLOT) table_links[prior] = table_links[at];
                    else head_slot = table_links[at];
                    table_links[at] = free_slot;
                    free_slot = at;
                    if (key_total > 0) key_total--;
                end
            end
            CMD_SEARCH: begin
                at = find_key(k, prior);
                if (at >= NO_SLOT) res.status = ST_MISSING;
                else res.position = at[5:0];
            end
            CMD_COUNT: begin
                res.count = key_total;
            end
            CMD_LAST_KEY: begin
                if (head_slot >= NO_SLOT) begin
                    res.status = ST_EMPTY;
                end else begin
                    at = head_slot;
                    steps = 0;
                    while (table_links[at] < NO_SLOT && steps < ENTRIES) begin
                        at = table_links[at];
                        steps++;
                    end
                    res.value = table_keys[at];
                end
            end
            CMD_SLOT_KEY: begin
                if (int'(s) < ENTRIES) res.value = table_keys[s];
                else res.status = ST_MISSING;
            end
            default: begin
                res.status = ST_MISSING;
            end
        endcase
        return res;
    endfunction

    // small keys collide often, store picks hit live and stale keys
    function automatic t_key pick_key();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return t_key'($urandom_range(0, 80)) - 32'sd40;
        if (roll < 80) return table_keys[$urandom_range(0, ENTRIES - 1)];
        if (roll < 95) return t_key'($urandom);
        return roll[0] ? KEY_MAX : KEY_MIN;
    endfunction

    function automatic t_cmd_code pick_cmd(input t_phase phase);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return roll[0] ? CMD_SPARE_LO : CMD_SPARE_HI;
        case (phase)
            PH_FILL:  if (roll < 75) return CMD_INSERT;
            PH_DRAIN: if (roll < 70) return CMD_DELETE;
            default: begin
                if (roll < 35) return CMD_INSERT;
                if (roll < 60) return CMD_DELETE;
            end
        endcase
        case ($urandom_range(0, 3))
            0:       return CMD_SEARCH;
            1:       return CMD_COUNT;
            2:       return CMD_LAST_KEY;
            default: return CMD_SLOT_KEY;
        endcase
    endfunction

    task automatic push_cmd(input t_cmd_code c, input t_key k, input t_slot s,
                            input logic typed, input t_outcome typed_want);
        t_outcome outcome;
        while (!steady && $urandom_range(0, 99) < 36) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= c;
        cmd_if.key     <= k;
        cmd_if.slot    <= s;
        @(posedge i_clk);
        while (cmd_if.ready !== 1'b1) @(posedge i_clk);
        outcome = apply_cmd(c, k, s);
        expected_results.push_back(typed ? typed_want : outcome);
    endtask

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got = '{res_if.status, res_if.position, res_if.value, res_if.count};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d position %0d value %0d count %0d",
                         $time, got.status, got.position, got.value, got.count);
                fault_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.position !== want.position ||
                    got.value !== want.value || got.count !== want.count) begin
                    $display("%0t: mismatch expected status %0d position %0d value %0d count %0d",
                             $time, want.status, want.position, want.value, want.count);
                    $display("%0t:          actual   status %0d position %0d value %0d count %0d",
                             $time, got.status, got.position, got.value, got.count);
                    fault_count++;
                end
            end
        end
        res_if.ready <= steady || ($urandom_range(0, 99) >= 36);
    end

    initial begin
        int     n;
        int     m;
        t_phase phase;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= CMD_COUNT;
        cmd_if.key     <= '0;
        cmd_if.slot    <= '0;
        i_rst_n        <= 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            table_keys[i]  = '0;
            table_links[i] = 7'(i + 1);
        end
        head_slot = NO_SLOT;
        free_slot = '0;
        key_total = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_STEPS[i]) begin
            push_cmd(DIRECTED_STEPS[i].command, DIRECTED_STEPS[i].key, DIRECTED_STEPS[i].slot,
                     DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
        end

        // fill phase, drain phase, then a mixed stretch, in rounds of 400 items
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            m = n % 400;
            if (m < 150) phase = PH_FILL;
            else if (m < 300) phase = PH_DRAIN;
            else phase = PH_MIXED;
            steady = (n >= 500 && n < 800);
            push_cmd(pick_cmd(phase), pick_key(), t_slot'($urandom), 1'b0, NO_WANT);
        end
        steady = 1'b0;
        cmd_if.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
